[src/llra_pkg.sv]
`timescale 1ns / 1ps
// shared widths, register indexes and control types for the least-loaded row assigner
// no dependencies
package llra_pkg;

  localparam int unsigned FILL_W       = 16;
  localparam int unsigned ITEM_W       = 10;
  localparam int unsigned GAP_W        = 8;
  localparam int unsigned ROW_CNT_W    = 5;
  localparam int unsigned ROW_OUT_W    = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned MAX_ROWS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 2'd1;

  // control of the shared compare unit
  typedef struct packed {
    logic start;  // open a new scan
    logic take;   // a row fill sample is presented
  } llra_cmp_ctl_t;

endpackage

[src/least_loaded_row_assigner_core.sv]
`timescale 1ns / 1ps
// least-loaded row assigner: takes one request at a time and stalls new ones until its result
// is committed. Per request: n reads through one ram read port (n = rows in use), the last compare
// on the shared comparator, leaving the scan, an update that waits for a free result slot, idle.
// reset: row_count 1, gap 0, no batch open, all rows unwritten, output slot empty.
// depends on llra_pkg, llra_fill_ram, llra_cmp_unit
module least_loaded_row_assigner_core import llra_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ITEM_W-1:0]     item_width_i,
  input  logic                  batch_end_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ROW_OUT_W-1:0]  chosen_row_o,
  output logic [FILL_W-1:0]     widest_fill_o,
  output logic                  final_flag_o
);

  // row address and row counter widths
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [ROW_CNT_W-1:0] row_count_q;
  logic [GAP_W-1:0]     gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_CNT_W'(1);
      gap_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT: row_count_q <= cfg_data_i[ROW_CNT_W-1:0];
        CFG_GAP:       gap_q       <= cfg_data_i[GAP_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // rows in use: zero treated as one, clipped to the row capacity
  logic [CW-1:0] rows_n;
  always_comb begin
    if (32'(row_count_q) > 32'(MAX_ROWS)) begin
      rows_n = CW'(MAX_ROWS);
    end else if (row_count_q == '0) begin
      rows_n = CW'(1);
    end else begin
      rows_n = CW'(row_count_q);
    end
  end

  // request handshake: one request at a time
  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // per-request context
  logic [ITEM_W-1:0] width_q;
  logic              last_q;
  logic [CW-1:0]     n_q;
  logic              batch_open_q;
  logic [GAP_W-1:0]  batch_gap_q;

  // scan sequencing: issue counter and the read in flight
  logic [CW-1:0] rd_cnt_q;
  logic          cmp_pend_q;
  logic [AW-1:0] cmp_idx_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < n_q);
  assign rd_addr = rd_cnt_q[AW-1:0];

  // result slot
  logic                 out_valid_q;
  logic [ROW_OUT_W-1:0] chosen_row_q;
  logic [FILL_W-1:0]    widest_fill_q;
  logic                 final_flag_q;
  logic                 slot_free;
  logic                 commit;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == ST_UPD) && slot_free;

  // compare unit and storage hookup
  llra_cmp_ctl_t     cmp_ctl;
  logic [FILL_W-1:0] rd_data;
  logic [AW-1:0]     best_idx;
  logic [FILL_W-1:0] best_fill;
  logic [FILL_W-1:0] max_fill;

  assign cmp_ctl.start = in_acc;
  assign cmp_ctl.take  = (state_q == ST_SCAN) && cmp_pend_q;

  // chosen row fill after the item, saturated
  logic [FILL_W:0]   fill_sum;
  logic [FILL_W-1:0] new_fill;
  logic [FILL_W-1:0] widest;

  assign fill_sum = {1'b0, best_fill} + (FILL_W + 1)'(width_q) + (FILL_W + 1)'(gap_q);
  assign new_fill = fill_sum[FILL_W] ? {FILL_W{1'b1}} : fill_sum[FILL_W-1:0];
  // the chosen row was the minimum, so only it can push the maximum up
  assign widest   = (new_fill > max_fill) ? new_fill : max_fill;

  llra_fill_ram #(
    .DEPTH (MAX_ROWS),
    .AW    (AW)
  ) u_fill_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (in_acc && !batch_open_q),
    .wr_en_i   (commit),
    .wr_addr_i (best_idx),
    .wr_data_i (new_fill),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .dflt_i    (FILL_W'(batch_gap_q)),
    .rd_data_o (rd_data)
  );

  llra_cmp_unit #(
    .AW (AW)
  ) u_cmp_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cmp_ctl),
    .idx_i       (cmp_idx_q),
    .fill_i      (rd_data),
    .best_idx_o  (best_idx),
    .best_fill_o (best_fill),
    .max_fill_o  (max_fill)
  );

  // sequencer: idle -> scan every row in use -> update and hand over the result
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rd_en && !cmp_pend_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      batch_open_q <= 1'b0;
      rd_cnt_q     <= '0;
      cmp_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        rd_cnt_q   <= '0;
        cmp_pend_q <= 1'b0;
        if (!batch_open_q) begin
          batch_open_q <= 1'b1;
        end
      end else begin
        cmp_pend_q <= rd_en;
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
      end
      // batch closes once its last request is committed
      if (commit && last_q) begin
        batch_open_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      width_q <= item_width_i;
      last_q  <= batch_end_i;
      n_q     <= rows_n;
      if (!batch_open_q) begin
        batch_gap_q <= gap_q;
      end
    end
    if (rd_en) begin
      cmp_idx_q <= rd_addr;
    end
    if (commit) begin
      chosen_row_q  <= ROW_OUT_W'(best_idx);
      widest_fill_q <= last_q ? widest : '0;
      final_flag_q  <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_row_o  = chosen_row_q;
  assign widest_fill_o = widest_fill_q;
  assign final_flag_o  = final_flag_q;

endmodule

[src/llra_fill_ram.sv]
`timescale 1ns / 1ps
// row fill storage: single-port write, registered read, per-row valid bits
// depends on llra_pkg
module llra_fill_ram import llra_pkg::*; #(
  parameter int unsigned DEPTH = MAX_ROWS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [FILL_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [FILL_W-1:0] dflt_i,
  output logic [FILL_W-1:0] rd_data_o
);

  logic [FILL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [FILL_W-1:0] rd_data_q;

  // a row not written since the batch opened reads as the batch gap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : dflt_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/llra_cmp_unit.sv]
`timescale 1ns / 1ps
// shared compare unit: running minimum (lowest index on tie) and maximum
// depends on llra_pkg
module llra_cmp_unit import llra_pkg::*; #(
  parameter int unsigned AW = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llra_cmp_ctl_t     ctl_i,
  input  logic [AW-1:0]     idx_i,
  input  logic [FILL_W-1:0] fill_i,
  output logic [AW-1:0]     best_idx_o,
  output logic [FILL_W-1:0] best_fill_o,
  output logic [FILL_W-1:0] max_fill_o
);

  logic              first_q;
  logic [AW-1:0]     best_idx_q;
  logic [FILL_W-1:0] best_fill_q;
  logic [FILL_W-1:0] max_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (ctl_i.start) begin
      first_q <= 1'b1;
    end else if (ctl_i.take) begin
      first_q <= 1'b0;
    end
  end

  // strict compare keeps the earlier (lower) row on a tie
  always_ff @(posedge clk_i) begin
    if (ctl_i.take && !ctl_i.start) begin
      if (first_q || (fill_i < best_fill_q)) begin
        best_fill_q <= fill_i;
        best_idx_q  <= idx_i;
      end
      if (first_q || (fill_i > max_fill_q)) begin
        max_fill_q <= fill_i;
      end
    end
  end

  assign best_idx_o  = best_idx_q;
  assign best_fill_o = best_fill_q;
  assign max_fill_o  = max_fill_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for least_loaded_row_assigner_core: a directed script, then random
// batches checked against a placement predictor kept inside the bench; depends on llra_pkg
module testbench;
  import llra_pkg::*;

  localparam int unsigned ROWS        = MAX_ROWS_DEF;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned WATCH_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SAT_BURST   = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [FILL_W-1:0]    FILL_TOP    = '1;

  // one placement as the block reports it
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [FILL_W-1:0]    widest;
    logic                 last;
  } placement_t;

  typedef enum logic [1:0] {STEP_PLACE, STEP_WRITE, STEP_SETTLE} step_kind_e;

  // one row of the directed script; known rows carry a hand-worked placement
  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ITEM_W-1:0]     width;
    logic                  last;
    logic                  known;
    placement_t            want;
  } step_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic [ITEM_W-1:0]     item_width = '0;
  logic                  batch_end  = 1'b0;
  logic                  out_stall  = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [ROW_OUT_W-1:0]  chosen_row;
  logic [FILL_W-1:0]     widest_fill;
  logic                  final_flag;

  // predictor state: row fills, register copies and the open-batch flag
  logic [FILL_W-1:0]    shadow_fill [ROWS];
  logic [ROW_CNT_W-1:0] shadow_rows = 5'd1;
  logic [GAP_W-1:0]     shadow_gap  = '0;
  bit                   shadow_open = 1'b0;
  placement_t           placements_due [$];

  bit          steady    = 1'b0;  // both sides run without idling
  bit          long_hold = 1'b0;  // result side holds off for a long stretch
  int unsigned requests_sent   = 0;
  int unsigned batches_closed  = 0;
  int unsigned writes_done     = 0;
  int unsigned results_checked = 0;
  int unsigned setups          = 0;
  int unsigned fault_count     = 0;
  int unsigned idle_cycles     = 0;

  least_loaded_row_assigner_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .item_width_i  (item_width),
    .batch_end_i   (batch_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .chosen_row_o  (chosen_row),
    .widest_fill_o (widest_fill),
    .final_flag_o  (final_flag)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // greedy least-loaded placement: lowest index wins a tie, fills saturate
  function automatic placement_t place_item(input logic [ITEM_W-1:0] w, input logic last);
    placement_t        res;
    int unsigned       n;
    int unsigned       best;
    int unsigned       sum;
    logic [FILL_W-1:0] widest;
    n = (shadow_rows == 0) ? 1 : ((shadow_rows > ROWS) ? ROWS : shadow_rows);
    if (!shadow_open) begin
      for (int i = 0; i < ROWS; i++) shadow_fill[i] = shadow_gap;
      shadow_open = 1'b1;
    end
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (shadow_fill[i] < shadow_fill[best]) best = i;
    end
    sum = shadow_fill[best] + w + shadow_gap;
    shadow_fill[best] = (sum > FILL_TOP) ? FILL_TOP : FILL_W'(sum);
    widest = '0;
    if (last) begin
      for (int i = 0; i < n; i++) begin
        if (shadow_fill[i] > widest) widest = shadow_fill[i];
      end
      shadow_open = 1'b0;
    end
    res.row    = ROW_OUT_W'(best);
    res.widest = widest;
    res.last   = last;
    return res;
  endfunction

  function automatic step_t place_row(input logic [ITEM_W-1:0] w, input logic last);
    step_t s;
    s       = '0;
    s.kind  = STEP_PLACE;
    s.width = w;
    s.last  = last;
    return s;
  endfunction

  function automatic step_t place_known(input logic [ITEM_W-1:0] w, input logic last,
                                        input logic [ROW_OUT_W-1:0] row,
                                        input logic [FILL_W-1:0] widest);
    step_t s;
    s             = place_row(w, last);
    s.known       = 1'b1;
    s.want.row    = row;
    s.want.widest = widest;
    s.want.last   = last;
    return s;
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s      = '0;
    s.kind = STEP_WRITE;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t settle_row();
    step_t s;
    s      = '0;
    s.kind = STEP_SETTLE;
    return s;
  endfunction

  // offer one request; valid stays high after acceptance unless the next one idles first
  task automatic offer(input logic [ITEM_W-1:0] w, input logic last, input logic known,
                       input placement_t want);
    int unsigned pause;
    placement_t  res;
    pause = steady ? 0 : $urandom_range(0, 19);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid   <= 1'b1;
    item_width <= w;
    batch_end  <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    res = place_item(w, last);
    placements_due.insert(placements_due.size(), known ? want : res);
    requests_sent++;
    if (last) batches_closed++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_ROW_COUNT) shadow_rows = data[ROW_CNT_W-1:0];
    else if (idx == CFG_GAP) shadow_gap = data;
    writes_done++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every placement has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_placement(input placement_t got);
    placement_t want;
    if (placements_due.size() == 0) begin
      $error("placement with none due: row %0d widest %0d final %0d",
             got.row, got.widest, got.last);
      fault_count++;
    end else begin
      want = placements_due.pop_front();
      results_checked++;
      if (got.row != want.row) begin
        $error("chosen_row: expected %0d, got %0d", want.row, got.row);
        fault_count++;
      end
      if (got.widest != want.widest) begin
        $error("widest_fill: expected %0d, got %0d", want.widest, got.widest);
        fault_count++;
      end
      if (got.last != want.last) begin
        $error("final_flag: expected %0d, got %0d", want.last, got.last);
        fault_count++;
      end
    end
  endtask

  // result side: random hold-offs per result, one long hold when asked
  initial begin : result_sink
    int unsigned pause;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        pause = steady ? 0 : $urandom_range(0, 19);
        if (pause != 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      check_placement(placement_t'({chosen_row, widest_fill, final_flag}));
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    step_t                 script [$];
    int unsigned           phase;
    int unsigned           pick;
    int unsigned           rows_eff;
    int unsigned           batch_left;
    int unsigned           burst;
    logic [CFG_DATA_W-1:0] rc_data;
    logic [CFG_DATA_W-1:0] gap_data;
    logic [ITEM_W-1:0]     w;
    logic                  last;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: one row, no gap
    script.insert(script.size(), place_known(10'd0, 1'b1, 4'd0, 16'd0));
    script.insert(script.size(), place_known(10'd1023, 1'b1, 4'd0, 16'd1023));
    // all rows, widest gap; first two items go to rows 0 and 1
    script.insert(script.size(), settle_row());
    script.insert(script.size(), reg_row(CFG_ROW_COUNT, 8'd16));
    script.insert(script.size(), reg_row(CFG_GAP, 8'd255));
    script.insert(script.size(), place_known(10'd1023, 1'b0, 4'd0, 16'd0));
    script.insert(script.size(), place_known(10'd0, 1'b0, 4'd1, 16'd0));
    script.insert(script.size(), place_row(10'd512, 1'b0));
    script.insert(script.size(), place_row(10'd17, 1'b0));
    // gap changed with the batch still open
    script.insert(script.size(), settle_row());
    script.insert(script.size(), reg_row(CFG_GAP, 8'd0));
    script.insert(script.size(), place_row(10'd300, 1'b0));
    script.insert(script.size(), place_row(10'd1, 1'b0));
    // row count shrunk with the batch still open
    script.insert(script.size(), settle_row());
    script.insert(script.size(), reg_row(CFG_ROW_COUNT, 8'd3));
    script.insert(script.size(), place_row(10'd9, 1'b0));
    script.insert(script.size(), place_row(10'd682, 1'b1));
    // zero rows behaves as one row, new gap loaded at batch start
    script.insert(script.size(), settle_row());
    script.insert(script.size(), reg_row(CFG_ROW_COUNT, 8'd0));
    script.insert(script.size(), reg_row(CFG_GAP, 8'd255));
    script.insert(script.size(), place_known(10'd5, 1'b1, 4'd0, 16'd515));
    // oversized row count clips to the row limit, spare indexes do nothing
    script.insert(script.size(), settle_row());
    script.insert(script.size(), reg_row(CFG_ROW_COUNT, 8'hFF));
    script.insert(script.size(), reg_row(CFG_SPARE_2, 8'hAA));
    script.insert(script.size(), reg_row(CFG_SPARE_3, 8'h55));
    script.insert(script.size(), place_row(10'd341, 1'b0));
    script.insert(script.size(), place_row(10'd682, 1'b0));
    script.insert(script.size(), place_row(10'd1023, 1'b1));
    script.insert(script.size(), settle_row());
    script.insert(script.size(), reg_row(CFG_ROW_COUNT, 8'd2));
    script.insert(script.size(), reg_row(CFG_GAP, 8'h80));
    script.insert(script.size(), place_row(10'h155, 1'b0));
    script.insert(script.size(), place_row(10'h2AA, 1'b1));

    foreach (script[k]) begin
      case (script[k].kind)
        STEP_PLACE: begin
          offer(script[k].width, script[k].last, script[k].known, script[k].want);
        end
        STEP_WRITE: begin
          write_reg(script[k].idx, script[k].data);
        end
        default: begin
          settle();
        end
      endcase
    end

    // random setups, each followed by a burst of batches; a burst may end mid-batch
    phase      = 0;
    batch_left = 0;
    while (requests_sent < ITEM_TARGET) begin
      settle();
      setups++;
      steady = ($urandom_range(0, 3) == 0);
      if (phase % 10 == 3) begin
        // long batch on a single row to drive the fill into saturation
        write_reg(CFG_ROW_COUNT, 8'd1);
        write_reg(CFG_GAP, 8'd255);
        for (int k = 0; k < SAT_BURST; k++) begin
          offer(ITEM_W'($urandom_range(900, 1023)), (k == SAT_BURST - 1), 1'b0, '0);
        end
        batch_left = 0;
      end else begin
        pick = $urandom_range(0, 7);
        case (pick)
          0:       rc_data = 8'd0;
          1:       rc_data = 8'd1;
          2:       rc_data = 8'd16;
          3:       rc_data = CFG_DATA_W'($urandom_range(17, 31));
          4:       rc_data = CFG_DATA_W'($urandom);
          default: rc_data = CFG_DATA_W'($urandom_range(1, 16));
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
          0:       gap_data = 8'd0;
          1:       gap_data = 8'd255;
          default: gap_data = CFG_DATA_W'($urandom_range(0, 255));
        endcase
        if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_ROW_COUNT, rc_data);
        if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_GAP, gap_data);
        if ($urandom_range(0, 5) == 0) begin
          write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));
        end
        // block fills up behind a long result hold while requests keep coming
        if (phase % 12 == 5) begin
          steady    = 1'b1;
          long_hold = 1'b1;
        end
        rows_eff = (shadow_rows == 0) ? 1 : ((shadow_rows > ROWS) ? ROWS : shadow_rows);
        burst    = $urandom_range(20, 80);
        for (int k = 0; k < burst; k++) begin
          if (batch_left == 0) batch_left = $urandom_range(1, 3 * rows_eff);
          pick = $urandom_range(0, 7);
          if (pick == 0) w = '0;
          else if (pick == 1) w = '1;
          else w = ITEM_W'($urandom_range(0, 1023));
          batch_left--;
          last = (batch_left == 0);
          offer(w, last, 1'b0, '0);
        end
      end
      phase++;
    end

    settle();
    steady = 1'b0;
    repeat (ROWS + 8) @(posedge clk);
    $display("%0d requests in %0d closed batches, %0d register writes, %0d random setups",
             requests_sent, batches_closed, writes_done, setups);
    $display("%0d placements compared, %0d mismatches", results_checked, fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
